@@ src/crss_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the client record stack with code search
// no dependencies; imported by every module of the block

package crss_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	// field widths of the stream channels
	localparam int ACTION_W = 2;
	localparam int WORD_W = 32;
	localparam int AGE_W = 8;
	localparam int STATUS_W = 2;
	localparam int FOUND_DEPTH_W = 4;
	localparam int ENTRY_COUNT_W = 5;

	// input tdata layout, lowest bit first
	localparam int IN_TAG_LSB = 0;
	localparam int IN_CODE_LSB = IN_TAG_LSB + WORD_W;
	localparam int IN_AGE_LSB = IN_CODE_LSB + WORD_W;
	localparam int IN_SALARY_LSB = IN_AGE_LSB + AGE_W;
	localparam int IN_SEARCH_LSB = IN_SALARY_LSB + WORD_W;
	localparam int IN_BITS = IN_SEARCH_LSB + WORD_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	// output tdata layout, lowest bit first
	localparam int OUT_STATUS_LSB = 0;
	localparam int OUT_FOUND_LSB = OUT_STATUS_LSB + STATUS_W;
	localparam int OUT_DEPTH_LSB = OUT_FOUND_LSB + 1;
	localparam int OUT_COUNT_LSB = OUT_DEPTH_LSB + FOUND_DEPTH_W;
	localparam int OUT_BITS = OUT_COUNT_LSB + ENTRY_COUNT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH   = 2'd0,
		ACT_POP    = 2'd1,
		ACT_COUNT  = 2'd2,
		ACT_SEARCH = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] tag_number;
		logic signed [WORD_W-1:0] client_code;
		logic [AGE_W-1:0]         client_age;
		logic [WORD_W-1:0]        salary_bits;
	} record_t;

	// shift control broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctrl_t;

endpackage

@@ src/crss_cell.sv @@
`timescale 1ns / 1ps
// one stack slot: holds a record, shifts with its neighbors, compares its code
// depends on crss_pkg

module crss_cell
	import crss_pkg::*;
(
	input  logic                     clk,
	input  shift_ctrl_t              ctrl,
	input  record_t                  upper_rec,
	input  record_t                  lower_rec,
	input  logic signed [WORD_W-1:0] key,
	output record_t                  rec,
	output logic                     match
);

	record_t rec_q;

	// push moves records away from the top, pop pulls them back up
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			rec_q <= upper_rec;
		end else if (ctrl.pop) begin
			rec_q <= lower_rec;
		end
	end

	assign rec   = rec_q;
	assign match = (rec_q.client_code == key);

endmodule

@@ src/client_record_stack_search_top.sv @@
`timescale 1ns / 1ps
// client record stack: lifo of records in a shifting cell chain with code search
// depends on crss_pkg and crss_cell
//
// usage
// - input channel s_*: one transaction per action; s_tuser carries the action
//   (push, pop, count, search), s_tdata the record fields and the search code
// - output channel m_*: exactly one result transaction per input transaction,
//   in order: status, found flag, depth of the match from the top, and the
//   number of records held after the action
// - the stack is a row of cells; cell 0 is the top. a push shifts every cell
//   one place down, a pop one place up, and a search compares all cells at once
// - the result is registered and shows on m_* in the cycle after the
//   input transaction is accepted
// - throughput: one transaction per cycle, set by the single result register;
//   s_tready stays high while the result register is empty or being drained
// - when the receiver stalls, the result is held and further input is refused
//   until m_tready rises
// - reset clears the record count and the result valid flag; cell contents
//   are not reset and only slots below the count are ever looked at

module client_record_stack_search_top
	import crss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // tag_number, client_code, client_age, salary_bits, search_code
	input  logic [ACTION_W-1:0]   s_tuser,   // action
	// result channel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // status, found, found_depth, entry_count, zero pad
);

	logic                     accept;
	action_t                  action;
	record_t                  in_rec;
	logic signed [WORD_W-1:0] search_code;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             is_full;
	logic             is_empty;
	shift_ctrl_t      ctrl;

	// chain wiring
	record_t                cell_rec [STACK_DEPTH];
	record_t                upper_rec[STACK_DEPTH];
	record_t                lower_rec[STACK_DEPTH];
	logic [STACK_DEPTH-1:0] cell_match;
	logic [STACK_DEPTH-1:0] hit;

	logic             hit_any;
	logic [IDX_W-1:0] hit_idx;

	status_t status_d;

	// result register
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [OUT_DATA_W-1:0] m_data_d;

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// unpack the input transaction
	assign action                = action_t'(s_tuser);
	assign in_rec.tag_number     = s_tdata[IN_TAG_LSB +: WORD_W];
	assign in_rec.client_code    = s_tdata[IN_CODE_LSB +: WORD_W];
	assign in_rec.client_age     = s_tdata[IN_AGE_LSB +: AGE_W];
	assign in_rec.salary_bits    = s_tdata[IN_SALARY_LSB +: WORD_W];
	assign search_code           = s_tdata[IN_SEARCH_LSB +: WORD_W];

	assign is_full  = (count_q == CNT_W'(STACK_DEPTH));
	assign is_empty = (count_q == '0);

	assign ctrl.push = accept && (action == ACT_PUSH) && !is_full;
	assign ctrl.pop  = accept && (action == ACT_POP) && !is_empty;

	always_comb begin
		count_next = count_q;
		if (ctrl.push) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctrl.pop) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// row of cells, top at index 0
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_top
			assign upper_rec[i] = in_rec;
		end else begin : g_inner_up
			assign upper_rec[i] = cell_rec[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bottom
			// nothing below the last slot; its content is dead after a pop
			assign lower_rec[i] = cell_rec[i];
		end else begin : g_inner_dn
			assign lower_rec[i] = cell_rec[i+1];
		end

		crss_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.upper_rec (upper_rec[i]),
			.lower_rec (lower_rec[i]),
			.key       (search_code),
			.rec       (cell_rec[i]),
			.match     (cell_match[i])
		);

		// only occupied slots may report a match
		assign hit[i] = cell_match[i] && (CNT_W'(i) < count_q);
	end

	// first match from the top wins
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int d = STACK_DEPTH - 1; d >= 0; d--) begin
			if (hit[d]) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(d);
			end
		end
	end

	always_comb begin
		status_d = ST_OK;
		if (action == ACT_PUSH && is_full) begin
			status_d = ST_FULL;
		end else if (action == ACT_POP && is_empty) begin
			status_d = ST_EMPTY;
		end
	end

	always_comb begin
		m_data_d = '0;
		m_data_d[OUT_STATUS_LSB +: STATUS_W] = status_d;
		if (action == ACT_SEARCH && hit_any) begin
			m_data_d[OUT_FOUND_LSB]                  = 1'b1;
			m_data_d[OUT_DEPTH_LSB +: FOUND_DEPTH_W] = FOUND_DEPTH_W'(hit_idx);
		end
		m_data_d[OUT_COUNT_LSB +: ENTRY_COUNT_W] = ENTRY_COUNT_W'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= m_data_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

@@ src/crss_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the client record stack, bound to the top level
// depends on crss_pkg and client_record_stack_search_top

module crss_checker
	import crss_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	logic [STATUS_W-1:0]      res_status;
	logic                     res_found;
	logic [FOUND_DEPTH_W-1:0] res_depth;
	logic [ENTRY_COUNT_W-1:0] res_count;

	assign res_status = m_tdata[OUT_STATUS_LSB +: STATUS_W];
	assign res_found  = m_tdata[OUT_FOUND_LSB];
	assign res_depth  = m_tdata[OUT_DEPTH_LSB +: FOUND_DEPTH_W];
	assign res_count  = m_tdata[OUT_COUNT_LSB +: ENTRY_COUNT_W];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// empty result register always takes input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input refused with empty result register");

	// a match only comes with an ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_found |-> res_status == ST_OK)
		else $error("match reported with error status");

	// no match means depth zero
	a_depth_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_found |-> res_depth == '0)
		else $error("nonzero depth without a match");

	// a refused pop leaves the stack empty
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_status == ST_EMPTY |-> res_count == '0)
		else $error("empty status with nonzero count");

endmodule

bind client_record_stack_search_top crss_checker u_crss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ dv/crss_stack_checker.sv @@
`timescale 1ns / 1ps
// checker for the client record stack: watches both stream channels, keeps its own
// stack of records, predicts each result and compares it field by field
// depends on crss_pkg

module crss_stack_checker
	import crss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // tag_number, client_code, client_age, salary_bits, search_code
	input  logic [ACTION_W-1:0]   s_tuser,   // action
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // status, found, found_depth, entry_count, zero pad
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		status_t                  status;
		logic                     found;
		logic [FOUND_DEPTH_W-1:0] found_depth;
		logic [ENTRY_COUNT_W-1:0] entry_count;
	} stack_outcome_t;

	// shadow stack, slot 0 is the bottom
	record_t        shadow_records [STACK_DEPTH];
	int             shadow_count;
	stack_outcome_t outcome_q [$];

	task automatic check_field(input string field, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_val,
				act_val);
			fail_count++;
		end
	endtask

	// applies one action to the shadow stack and returns the result it causes
	function automatic stack_outcome_t apply_stack_action(input action_t act,
			input logic [IN_DATA_W-1:0] fields);
		stack_outcome_t res;
		record_t        rec;
		logic [WORD_W-1:0] key;
		int             d;
		res = '{status: ST_OK, found: 1'b0, found_depth: '0, entry_count: '0};
		rec.tag_number  = fields[IN_TAG_LSB +: WORD_W];
		rec.client_code = fields[IN_CODE_LSB +: WORD_W];
		rec.client_age  = fields[IN_AGE_LSB +: AGE_W];
		rec.salary_bits = fields[IN_SALARY_LSB +: WORD_W];
		key = fields[IN_SEARCH_LSB +: WORD_W];
		case (act)
			ACT_PUSH: begin
				if (shadow_count >= STACK_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					shadow_records[shadow_count] = rec;
					shadow_count++;
				end
			end
			ACT_POP: begin
				if (shadow_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					shadow_count--;
				end
			end
			ACT_SEARCH: begin
				// scan from the top down, the nearest match wins
				d = 0;
				while (d < shadow_count && !res.found) begin
					if (shadow_records[shadow_count - 1 - d].client_code == key) begin
						res.found = 1'b1;
						res.found_depth = d[FOUND_DEPTH_W-1:0];
					end
					d++;
				end
			end
			default: ;
		endcase
		res.entry_count = shadow_count[ENTRY_COUNT_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stack_outcome_t exp_res;
		if (!arst_n) begin
			shadow_count = 0;
			outcome_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// a result always belongs to an action accepted at an earlier edge
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: result with no action waiting, actual %0h", $time,
						m_tdata);
					fail_count++;
				end else begin
					exp_res = outcome_q.pop_front();
					check_field("status", int'(exp_res.status),
						int'(m_tdata[OUT_STATUS_LSB +: STATUS_W]));
					check_field("found", int'(exp_res.found),
						int'(m_tdata[OUT_FOUND_LSB]));
					check_field("found_depth", int'(exp_res.found_depth),
						int'(m_tdata[OUT_DEPTH_LSB +: FOUND_DEPTH_W]));
					check_field("entry_count", int'(exp_res.entry_count),
						int'(m_tdata[OUT_COUNT_LSB +: ENTRY_COUNT_W]));
				end
			end
			if (s_tvalid && s_tready) begin
				outcome_q.push_back(apply_stack_action(action_t'(s_tuser), s_tdata));
			end
			pending = outcome_q.size();
		end
	end

endmodule

@@ dv/tb_client_record_stack_search_top.sv @@
`timescale 1ns / 1ps
// testbench top for the client record stack: drives actions and the result stall
// pattern, runs a watchdog and prints the verdict
// depends on crss_pkg, client_record_stack_search_top and crss_stack_checker

module tb_client_record_stack_search_top;
	import crss_pkg::*;

	localparam int RANDOM_ITEMS = 750;
	localparam int IDLE_LIMIT   = 1000;   // well above the long receiver hold-off
	localparam int HOLD_CYCLES  = 120;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // tag_number, client_code, client_age, salary_bits, search_code
	logic [ACTION_W-1:0]   s_tuser;   // action
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // status, found, found_depth, entry_count, zero pad

	int mismatches;
	int pending;
	int idle_cycles;
	bit hold_request;   // asks the receiver for its one long hold-off

	client_record_stack_search_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	crss_stack_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (mismatches),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// watchdog: cycles in which neither channel moves a transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_client_record_stack_search_top: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// offers one action and holds it until the transaction completes;
	// called and returning at a falling edge
	task automatic send_action(input action_t act, input logic [WORD_W-1:0] tag,
			input logic [WORD_W-1:0] code, input logic [AGE_W-1:0] age,
			input logic [WORD_W-1:0] salary, input logic [WORD_W-1:0] key);
		logic [IN_DATA_W-1:0] fields;
		fields = '0;
		fields[IN_TAG_LSB +: WORD_W]    = tag;
		fields[IN_CODE_LSB +: WORD_W]   = code;
		fields[IN_AGE_LSB +: AGE_W]     = age;
		fields[IN_SALARY_LSB +: WORD_W] = salary;
		fields[IN_SEARCH_LSB +: WORD_W] = key;
		s_tdata  = fields;
		s_tuser  = act;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// action with random content in every field that does not matter for it
	task automatic send_plain(input action_t act, input logic [WORD_W-1:0] key);
		send_action(act, $urandom, $urandom, AGE_W'($urandom_range(0, 255)), $urandom, key);
	endtask

	// receiver: segments of different stall patterns, plus one long hold-off
	initial begin
		bit hold_done;
		int seg_len;
		int pattern;
		hold_done = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			pattern = $urandom_range(0, 3);
			seg_len = $urandom_range(20, 100);
			for (int k = 0; k < seg_len; k++) begin
				@(negedge clk);
				if (hold_request && !hold_done) begin
					// block fills up and must refuse input while this lasts
					for (int h = 0; h < HOLD_CYCLES; h++) begin
						m_tready = 1'b0;
						@(negedge clk);
					end
					hold_done = 1'b1;
				end
				case (pattern)
					0: m_tready = 1'b1;                            // no stalls at all
					1: m_tready = ($urandom_range(0, 1) == 0);
					2: m_tready = (k % 4 == 3);                    // one cycle in four
					default: m_tready = ($urandom_range(0, 99) < 85);
				endcase
			end
		end
	end

	initial begin
		logic [WORD_W-1:0] pool_base;
		int pool_size;
		int phase;
		int phase_left;
		int burst_left;
		int gap;
		int pick;
		int push_pct;
		int pop_pct;
		int count_pct;
		logic [WORD_W-1:0] code;
		logic [WORD_W-1:0] key;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ACT_COUNT;
		hold_request = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty stack corner cases
		send_plain(ACT_POP, $urandom);
		send_plain(ACT_COUNT, $urandom);
		send_plain(ACT_SEARCH, 32'h0000_0000);

		// fill to the top with extreme field values; the largest code sits twice
		send_action(ACT_PUSH, 32'h8000_0000, 32'h8000_0000, 8'd0, 32'h0000_0000, $urandom);
		send_action(ACT_PUSH, 32'h7fff_ffff, 32'h7fff_ffff, 8'd255, 32'hffff_ffff, $urandom);
		for (int i = 2; i < STACK_DEPTH; i++) begin
			code = (i == STACK_DEPTH - 4) ? 32'h7fff_ffff : 32'd1000 + i;
			send_action(ACT_PUSH, $urandom, code, AGE_W'($urandom_range(0, 255)), $urandom,
				$urandom);
		end
		// push refused on a full stack
		send_action(ACT_PUSH, $urandom, 32'd5, AGE_W'($urandom_range(0, 255)), $urandom,
			$urandom);
		// match at the bottom, at the top, nearest duplicate, and a miss
		send_plain(ACT_SEARCH, 32'h8000_0000);
		send_plain(ACT_SEARCH, 32'd1000 + STACK_DEPTH - 1);
		send_plain(ACT_SEARCH, 32'h7fff_ffff);
		send_plain(ACT_SEARCH, 32'h0001_2345);
		send_plain(ACT_COUNT, $urandom);

		// sender pause until every result is back
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);

		// random: phases that lean toward filling, draining or mixing the stack,
		// with client codes drawn mostly from a small pool so searches hit
		phase_left = 0;
		burst_left = $urandom_range(1, 24);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				phase = $urandom_range(0, 2);
				phase_left = $urandom_range(10, 60);
				pool_base = $urandom;
				pool_size = $urandom_range(1, 32);
			end
			phase_left--;
			case (phase)
				0:       begin push_pct = 60; pop_pct = 10; count_pct = 5; end
				1:       begin push_pct = 10; pop_pct = 55; count_pct = 5; end
				default: begin push_pct = 35; pop_pct = 30; count_pct = 10; end
			endcase
			if (n == 200) begin
				hold_request = 1'b1;
			end
			code = ($urandom_range(0, 99) < 80) ?
				pool_base + $urandom_range(0, pool_size - 1) : $urandom;
			key = ($urandom_range(0, 99) < 85) ?
				pool_base + $urandom_range(0, pool_size - 1) : $urandom;
			pick = $urandom_range(0, 99);
			if (pick < push_pct) begin
				send_action(ACT_PUSH, $urandom, code, AGE_W'($urandom_range(0, 255)),
					$urandom, key);
			end else if (pick < push_pct + pop_pct) begin
				send_plain(ACT_POP, key);
			end else if (pick < push_pct + pop_pct + count_pct) begin
				send_plain(ACT_COUNT, key);
			end else begin
				send_action(ACT_SEARCH, $urandom, code, AGE_W'($urandom_range(0, 255)),
					$urandom, key);
			end
			// bursts of random length separated by random gaps
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					s_tvalid = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end

		// drain, then give a stray result a chance to show up
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("tb_client_record_stack_search_top: clean");
		end else begin
			$display("tb_client_record_stack_search_top: errors");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/crss_pkg.sv
src/crss_cell.sv
src/client_record_stack_search_top.sv
src/crss_checker.sv
dv/crss_stack_checker.sv
dv/tb_client_record_stack_search_top.sv
